/* hdl/plp_pkg.sv */
package plp_pkg;

  localparam int unsigned NumLanes = 3;

  typedef enum logic [1:0] {
    ModeLine    = 2'd0,
    ModeSegment = 2'd1,
    ModeRay     = 2'd2
  } mode_e;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusZeroDir = 2'd1;
  localparam logic [1:0] StatusSat     = 2'd2;

  typedef struct packed {
    logic zero_den;
    logic num_neg;
    logic clamp_a;
    logic clamp_end;
  } flags_t;

endpackage

/* hdl/plp_front.sv */
module plp_front
  import plp_pkg::*;
#(
  parameter int unsigned CoordWidth = 16
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [1:0]                   req_type_i,
  input  logic signed [CoordWidth-1:0] q_i [NumLanes],
  input  logic signed [CoordWidth-1:0] a_i [NumLanes],
  input  logic signed [CoordWidth-1:0] d_i [NumLanes],
  output flags_t                       flags_o,
  output logic [2*CoordWidth:0]        mag_o,
  output logic [2*CoordWidth-1:0]      den_o,
  output logic signed [CoordWidth-1:0] a_o [NumLanes],
  output logic [CoordWidth-1:0]        dm_o [NumLanes],
  output logic [NumLanes-1:0]          dneg_o
);

  localparam int unsigned W    = CoordWidth;
  localparam int unsigned PnW  = 2 * W + 1;
  localparam int unsigned DdW  = 2 * W;
  localparam int unsigned NumW = 2 * W + 3;
  localparam int unsigned DenW = 2 * W;
  localparam int unsigned MagW = 2 * W + 1;

  logic signed [W:0]     diff [NumLanes];
  logic signed [PnW-1:0] pn_d [NumLanes];
  logic [DdW-1:0]        dd_d [NumLanes];

  logic signed [PnW-1:0] pn_q [NumLanes];
  logic [DdW-1:0]        dd_q [NumLanes];
  logic [1:0]            mode_q1;
  logic signed [W-1:0]   a_q1 [NumLanes];
  logic signed [W-1:0]   d_q1 [NumLanes];

  logic signed [NumW-1:0] num_d;
  logic [DenW-1:0]        den_d;
  logic signed [NumW-1:0] num_q;
  logic [DenW-1:0]        den_q;
  logic [1:0]             mode_q2;
  logic signed [W-1:0]    a_q2 [NumLanes];
  logic signed [W-1:0]    d_q2 [NumLanes];

  logic                   num_neg;
  logic                   is_seg;
  logic                   is_ray;
  logic [NumW-1:0]        mag_full;
  logic [MagW-1:0]        mag_d;
  flags_t                 flags_d;
  logic [W-1:0]           dm_d [NumLanes];
  logic [NumLanes-1:0]    dneg_d;

  flags_t                 flags_q;
  logic [MagW-1:0]        mag_q;
  logic [DenW-1:0]        den_q3;
  logic signed [W-1:0]    a_q3 [NumLanes];
  logic [W-1:0]           dm_q [NumLanes];
  logic [NumLanes-1:0]    dneg_q;

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      diff[l] = {q_i[l][W-1], q_i[l]} - {a_i[l][W-1], a_i[l]};
      pn_d[l] = diff[l] * d_i[l];
      dd_d[l] = d_i[l] * d_i[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pn_q    <= pn_d;
      dd_q    <= dd_d;
      mode_q1 <= req_type_i;
      a_q1    <= a_i;
      d_q1    <= d_i;
    end
  end

  assign num_d = NumW'(pn_q[0]) + NumW'(pn_q[1]) + NumW'(pn_q[2]);
  assign den_d = dd_q[0] + dd_q[1] + dd_q[2];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q   <= num_d;
      den_q   <= den_d;
      mode_q2 <= mode_q1;
      a_q2    <= a_q1;
      d_q2    <= d_q1;
    end
  end

  always_comb begin
    num_neg  = num_q[NumW-1];
    mag_full = num_neg ? NumW'(-num_q) : NumW'(num_q);
    mag_d    = mag_full[MagW-1:0];
    is_seg   = (mode_q2 == ModeSegment);
    is_ray   = (mode_q2 == ModeRay);
    flags_d.zero_den  = (den_q == '0);
    flags_d.num_neg   = num_neg;
    flags_d.clamp_a   = (is_seg | is_ray) & (num_neg | (num_q == '0));
    flags_d.clamp_end = is_seg & ~num_neg & (mag_d >= MagW'(den_q));
    for (int l = 0; l < NumLanes; l++) begin
      dneg_d[l] = d_q2[l][W-1];
      dm_d[l]   = d_q2[l][W-1] ? (~d_q2[l] + 1'b1) : d_q2[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q <= flags_d;
      mag_q   <= mag_d;
      den_q3  <= den_q;
      a_q3    <= a_q2;
      dm_q    <= dm_d;
      dneg_q  <= dneg_d;
    end
  end

  assign flags_o = flags_q;
  assign mag_o   = mag_q;
  assign den_o   = den_q3;
  assign a_o     = a_q3;
  assign dm_o    = dm_q;
  assign dneg_o  = dneg_q;

endmodule

/* hdl/plp_scale.sv */
module plp_scale
  import plp_pkg::*;
#(
  parameter int unsigned CoordWidth = 16
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [2*CoordWidth:0]     mag_i,
  input  logic [CoordWidth-1:0]     dm_i [NumLanes],
  input  logic [2*CoordWidth-1:0]   den_i,
  output logic [3*CoordWidth-1:0]   prod_o [NumLanes],
  output logic [2*CoordWidth-1:0]   den_o
);

  localparam int unsigned W    = CoordWidth;
  localparam int unsigned MagW = 2 * W + 1;
  localparam int unsigned LoW  = 2 * W;
  localparam int unsigned HiW  = 2 * W + 1;
  localparam int unsigned PW   = 3 * W;
  localparam int unsigned DenW = 2 * W;

  logic [LoW-1:0]  pp_lo_d [NumLanes];
  logic [HiW-1:0]  pp_hi_d [NumLanes];
  logic [LoW-1:0]  pp_lo_q [NumLanes];
  logic [HiW-1:0]  pp_hi_q [NumLanes];
  logic [DenW-1:0] den_q1;
  logic [PW-1:0]   prod_d [NumLanes];
  logic [PW-1:0]   prod_q [NumLanes];
  logic [DenW-1:0] den_q2;

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      pp_lo_d[l] = LoW'(mag_i[W-1:0]) * LoW'(dm_i[l]);
      pp_hi_d[l] = HiW'(mag_i[MagW-1:W]) * HiW'(dm_i[l]);
      prod_d[l]  = PW'({pp_hi_q[l], {W{1'b0}}}) + PW'(pp_lo_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_lo_q <= pp_lo_d;
      pp_hi_q <= pp_hi_d;
      den_q1  <= den_i;
      prod_q  <= prod_d;
      den_q2  <= den_q1;
    end
  end

  assign prod_o = prod_q;
  assign den_o  = den_q2;

endmodule

/* hdl/plp_div.sv */
module plp_div
  import plp_pkg::*;
#(
  parameter int unsigned CoordWidth = 16
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [3*CoordWidth-1:0] prod_i [NumLanes],
  input  logic [2*CoordWidth-1:0] den_i,
  output logic [CoordWidth:0]     quo_o [NumLanes],
  output logic [NumLanes-1:0]     ovf_o
);

  localparam int unsigned W         = CoordWidth;
  localparam int unsigned PW        = 3 * W;
  localparam int unsigned CW        = 3 * W + 2;
  localparam int unsigned DenW      = 2 * W;
  localparam int unsigned DivStages = W + 2;

  logic [PW-1:0]       rem_q [DivStages][NumLanes];
  logic [W:0]          quo_q [DivStages][NumLanes];
  logic [NumLanes-1:0] ovf_q [DivStages];
  logic [DenW-1:0]     den_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    localparam int unsigned Sh = W + 1 - s;

    logic [PW-1:0]       rem_in [NumLanes];
    logic [DenW-1:0]     den_in;
    logic [CW-1:0]       den_sh;
    logic [NumLanes-1:0] ge;
    logic [PW-1:0]       rem_d [NumLanes];
    logic [W:0]          quo_d [NumLanes];
    logic [NumLanes-1:0] ovf_d;

    if (s == 0) begin : g_in
      assign rem_in = prod_i;
      assign den_in = den_i;
    end else begin : g_in
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
    end

    assign den_sh = CW'(den_in) << Sh;

    always_comb begin
      for (int l = 0; l < NumLanes; l++) begin
        ge[l] = (CW'(rem_in[l]) >= den_sh);
      end
    end

    if (s == 0) begin : g_step
      always_comb begin
        ovf_d = ge;
        rem_d = rem_in;
        for (int l = 0; l < NumLanes; l++) begin
          quo_d[l] = '0;
        end
      end
    end else begin : g_step
      logic [CW-1:0] sub [NumLanes];

      always_comb begin
        ovf_d = ovf_q[s-1];
        for (int l = 0; l < NumLanes; l++) begin
          sub[l]       = CW'(rem_in[l]) - den_sh;
          rem_d[l]     = ge[l] ? sub[l][PW-1:0] : rem_in[l];
          quo_d[l]     = quo_q[s-1][l];
          quo_d[l][Sh] = ge[l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
        ovf_q[s] <= ovf_d;
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];
  assign ovf_o = ovf_q[DivStages-1];

endmodule

/* hdl/point_line_projection.sv */
// Closest point on a 3D line, segment or ray, one query per beat.
// Input channel (in_valid_i / in_ready_o) carries the mode, query point Q,
// start point A and direction D. Output channel (out_valid_o / out_ready_i)
// returns the projected point and a status code: ok, zero direction (A is
// returned) or saturated.
// From input beat to output beat the pipeline has front stages that form the
// dot products, magnitude and clamp flags, scale stages that build the scaled
// numerators, divider stages that check for overflow and then run one restoring
// quotient bit per stage for all three axes, and an output stage that adds the
// offset to A, saturates and registers the result.
// Throughput is one beat per cycle for as long as the receiver takes
// results. The whole pipeline holds as one while a result waits in the
// output register and out_ready_i is low; in_ready_o is low for exactly
// those cycles, so nothing is dropped or repeated.
// Reset clears every valid bit and the output valid; no beat is in
// flight afterwards and there is nothing to configure.
module point_line_projection
  import plp_pkg::*;
#(
  parameter int unsigned CoordWidth = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   req_type_i,
  input  logic signed [CoordWidth-1:0] qx_i,
  input  logic signed [CoordWidth-1:0] qy_i,
  input  logic signed [CoordWidth-1:0] qz_i,
  input  logic signed [CoordWidth-1:0] ax_i,
  input  logic signed [CoordWidth-1:0] ay_i,
  input  logic signed [CoordWidth-1:0] az_i,
  input  logic signed [CoordWidth-1:0] dir_x_i,
  input  logic signed [CoordWidth-1:0] dir_y_i,
  input  logic signed [CoordWidth-1:0] dir_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [CoordWidth-1:0] rx_o,
  output logic signed [CoordWidth-1:0] ry_o,
  output logic signed [CoordWidth-1:0] rz_o,
  output logic [1:0]                   status_o
);

  localparam int unsigned W           = CoordWidth;
  localparam int unsigned MagW        = 2 * W + 1;
  localparam int unsigned DenW        = 2 * W;
  localparam int unsigned PW          = 3 * W;
  localparam int unsigned FrontStages = 3;
  localparam int unsigned ScaleStages = 2;
  localparam int unsigned DivStages   = W + 2;
  localparam int unsigned SideStages  = ScaleStages + DivStages;
  localparam int unsigned ValidStages = FrontStages + SideStages;
  localparam int unsigned MW          = W + 2;
  localparam int unsigned VW          = W + 3;

  typedef struct packed {
    logic signed [W-1:0] a;
    logic [W-1:0]        dm;
    logic                dneg;
  } lane_t;

  typedef struct packed {
    flags_t                    flags;
    lane_t [NumLanes-1:0]      lane;
  } side_t;

  logic                   adv;
  logic [ValidStages-1:0] vld_q;

  logic signed [W-1:0]    q_pt [NumLanes];
  logic signed [W-1:0]    a_pt [NumLanes];
  logic signed [W-1:0]    d_pt [NumLanes];

  flags_t                 fr_flags;
  logic [MagW-1:0]        fr_mag;
  logic [DenW-1:0]        fr_den;
  logic signed [W-1:0]    fr_a [NumLanes];
  logic [W-1:0]           fr_dm [NumLanes];
  logic [NumLanes-1:0]    fr_dneg;

  logic [PW-1:0]          sc_prod [NumLanes];
  logic [DenW-1:0]        sc_den;

  logic [W:0]             dv_quo [NumLanes];
  logic [NumLanes-1:0]    dv_ovf;

  side_t                  side_d;
  side_t                  side_q [SideStages];
  side_t                  side_o;

  logic [MW-1:0]          mag_off [NumLanes];
  logic                   off_neg [NumLanes];
  logic signed [VW-1:0]   a_ext [NumLanes];
  logic signed [VW-1:0]   v_sum [NumLanes];
  logic [NumLanes-1:0]    sat;
  logic signed [W-1:0]    res_d [NumLanes];
  logic [1:0]             status_d;
  logic signed [VW-1:0]   hi_lim;
  logic signed [VW-1:0]   lo_lim;
  logic [MW-1:0]          cap;

  logic                   out_valid_q;
  logic signed [W-1:0]    res_q [NumLanes];
  logic [1:0]             status_q;

  assign adv        = ~out_valid_q | out_ready_i;
  assign in_ready_o = adv;

  assign q_pt[0] = qx_i;
  assign q_pt[1] = qy_i;
  assign q_pt[2] = qz_i;
  assign a_pt[0] = ax_i;
  assign a_pt[1] = ay_i;
  assign a_pt[2] = az_i;
  assign d_pt[0] = dir_x_i;
  assign d_pt[1] = dir_y_i;
  assign d_pt[2] = dir_z_i;

  plp_front #(
    .CoordWidth (CoordWidth)
  ) u_front (
    .clk_i      (clk_i),
    .en_i       (adv),
    .req_type_i (req_type_i),
    .q_i        (q_pt),
    .a_i        (a_pt),
    .d_i        (d_pt),
    .flags_o    (fr_flags),
    .mag_o      (fr_mag),
    .den_o      (fr_den),
    .a_o        (fr_a),
    .dm_o       (fr_dm),
    .dneg_o     (fr_dneg)
  );

  plp_scale #(
    .CoordWidth (CoordWidth)
  ) u_scale (
    .clk_i  (clk_i),
    .en_i   (adv),
    .mag_i  (fr_mag),
    .dm_i   (fr_dm),
    .den_i  (fr_den),
    .prod_o (sc_prod),
    .den_o  (sc_den)
  );

  plp_div #(
    .CoordWidth (CoordWidth)
  ) u_div (
    .clk_i  (clk_i),
    .en_i   (adv),
    .prod_i (sc_prod),
    .den_i  (sc_den),
    .quo_o  (dv_quo),
    .ovf_o  (dv_ovf)
  );

  always_comb begin
    side_d.flags = fr_flags;
    for (int l = 0; l < NumLanes; l++) begin
      side_d.lane[l].a    = fr_a[l];
      side_d.lane[l].dm   = fr_dm[l];
      side_d.lane[l].dneg = fr_dneg[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int k = 1; k < SideStages; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign side_o = side_q[SideStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[ValidStages-2:0], in_valid_i};
    end
  end

  assign hi_lim = VW'({1'b0, {(W-1){1'b1}}});
  assign lo_lim = -hi_lim - VW'(1);
  assign cap    = MW'(1) << (W + 1);

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      if (side_o.flags.clamp_end) begin
        mag_off[l] = MW'(side_o.lane[l].dm);
        off_neg[l] = side_o.lane[l].dneg;
      end else begin
        mag_off[l] = dv_ovf[l] ? cap : MW'(dv_quo[l]);
        off_neg[l] = side_o.lane[l].dneg ^ side_o.flags.num_neg;
      end
      a_ext[l] = VW'(side_o.lane[l].a);
      v_sum[l] = off_neg[l] ? (a_ext[l] - VW'({1'b0, mag_off[l]}))
                            : (a_ext[l] + VW'({1'b0, mag_off[l]}));
      sat[l]   = 1'b0;
      res_d[l] = v_sum[l][W-1:0];
      if (v_sum[l] > hi_lim) begin
        sat[l]   = 1'b1;
        res_d[l] = hi_lim[W-1:0];
      end else if (v_sum[l] < lo_lim) begin
        sat[l]   = 1'b1;
        res_d[l] = lo_lim[W-1:0];
      end
    end
    status_d = (|sat) ? StatusSat : StatusOk;
    if (side_o.flags.zero_den || side_o.flags.clamp_a) begin
      for (int l = 0; l < NumLanes; l++) begin
        res_d[l] = side_o.lane[l].a;
      end
      status_d = side_o.flags.zero_den ? StatusZeroDir : StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[ValidStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q    <= res_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rx_o        = res_q[0];
  assign ry_o        = res_q[1];
  assign rz_o        = res_q[2];
  assign status_o    = status_q;

endmodule

/* tb/sv/point_line_projection_tb.sv */
`timescale 1ns / 1ps

module point_line_projection_tb;
  import plp_pkg::*;

  localparam int unsigned Cw = 16;
  localparam int unsigned ResultLatency = Cw + 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldOffCycles = 80;
  localparam logic [1:0] ModeUnused = 2'd3;

  typedef logic signed [Cw-1:0] coord_t;

  typedef struct packed {
    logic [1:0]   mode;
    coord_t [2:0] q;
    coord_t [2:0] a;
    coord_t [2:0] d;
  } query_t;

  typedef struct packed {
    coord_t [2:0] r;
    logic [1:0]   status;
  } point_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] req_type_i;
  coord_t     qx_i, qy_i, qz_i;
  coord_t     ax_i, ay_i, az_i;
  coord_t     dir_x_i, dir_y_i, dir_z_i;
  logic       out_valid_o;
  logic       out_ready_i;
  coord_t     rx_o, ry_o, rz_o;
  logic [1:0] status_o;

  point_t pending_points[$];
  int     mismatch_count;
  int     quiet_cycles;
  int     hold_left;
  bit     idle_en;
  string  axis_names[3] = '{"rx", "ry", "rz"};

  point_line_projection i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .qx_i       (qx_i),
    .qy_i       (qy_i),
    .qz_i       (qz_i),
    .ax_i       (ax_i),
    .ay_i       (ay_i),
    .az_i       (az_i),
    .dir_x_i    (dir_x_i),
    .dir_y_i    (dir_y_i),
    .dir_z_i    (dir_z_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .rx_o       (rx_o),
    .ry_o       (ry_o),
    .rz_o       (rz_o),
    .status_o   (status_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic point_t project_point(query_t qr);
    longint qv, av, dv, dm, den, num, mag, off, v, hi_lim, lo_lim;
    bit     neg_num, neg_off, clamp_end, sat;
    point_t p;
    den = 0;
    num = 0;
    sat = 1'b0;
    hi_lim = (longint'(1) <<< (Cw - 1)) - 1;
    lo_lim = -hi_lim - 1;
    for (int i = 0; i < 3; i++) begin
      qv = longint'($signed(qr.q[i]));
      av = longint'($signed(qr.a[i]));
      dv = longint'($signed(qr.d[i]));
      den += dv * dv;
      num += dv * (qv - av);
    end
    p.r = qr.a;
    if (den == 0) begin
      p.status = StatusZeroDir;
      return p;
    end
    p.status = StatusOk;
    if ((qr.mode == ModeSegment || qr.mode == ModeRay) && num <= 0) begin
      return p;
    end
    neg_num = num < 0;
    mag = neg_num ? -num : num;
    clamp_end = (qr.mode == ModeSegment) && (num >= den);
    for (int i = 0; i < 3; i++) begin
      av = longint'($signed(qr.a[i]));
      dv = longint'($signed(qr.d[i]));
      dm = (dv < 0) ? -dv : dv;
      if (clamp_end) begin
        off = dm;
        neg_off = dv < 0;
      end else begin
        off = (mag * dm) / den;
        neg_off = (dv < 0) != neg_num;
      end
      if (off > (longint'(1) <<< 33)) off = longint'(1) <<< 33;
      v = neg_off ? av - off : av + off;
      if (v > hi_lim) begin
        v = hi_lim;
        sat = 1'b1;
      end
      if (v < lo_lim) begin
        v = lo_lim;
        sat = 1'b1;
      end
      p.r[i] = coord_t'(v);
    end
    if (sat) p.status = StatusSat;
    return p;
  endfunction

  function automatic query_t make_query(logic [1:0] mode, int qx, int qy, int qz,
                                        int ax, int ay, int az, int dx, int dy, int dz);
    query_t qr;
    qr.mode = mode;
    qr.q[0] = coord_t'(qx);
    qr.q[1] = coord_t'(qy);
    qr.q[2] = coord_t'(qz);
    qr.a[0] = coord_t'(ax);
    qr.a[1] = coord_t'(ay);
    qr.a[2] = coord_t'(az);
    qr.d[0] = coord_t'(dx);
    qr.d[1] = coord_t'(dy);
    qr.d[2] = coord_t'(dz);
    return qr;
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 4))
      0: return coord_t'(-32768);
      1: return coord_t'(-1);
      2: return coord_t'(0);
      3: return coord_t'(1);
      default: return coord_t'(32767);
    endcase
  endfunction

  function automatic query_t random_query();
    query_t qr;
    int     kind, step;
    qr.mode = ($urandom_range(0, 15) == 0) ? ModeUnused : 2'($urandom_range(0, 2));
    for (int i = 0; i < 3; i++) begin
      qr.q[i] = coord_t'($urandom);
      qr.a[i] = coord_t'($urandom);
      qr.d[i] = coord_t'($urandom);
    end
    kind = $urandom_range(0, 19);
    if (kind >= 4 && kind < 12) begin
      step = $urandom_range(0, 8);
      for (int i = 0; i < 3; i++) begin
        qr.a[i] = coord_t'(int'($urandom_range(0, 40000)) - 20000);
        qr.d[i] = coord_t'(int'($urandom_range(0, 600)) - 300);
        qr.q[i] = coord_t'(int'(qr.a[i]) + int'(qr.d[i]) * (step - 2) / 4
                           + int'($urandom_range(0, 200)) - 100);
      end
    end else if (kind >= 12 && kind < 15) begin
      for (int i = 0; i < 3; i++) begin
        if ($urandom_range(0, 1) == 0) qr.d[i] = '0;
      end
    end else if (kind == 15) begin
      qr.d = '0;
    end else if (kind >= 16) begin
      for (int i = 0; i < 3; i++) begin
        qr.q[i] = pick_extreme();
        qr.a[i] = pick_extreme();
        qr.d[i] = pick_extreme();
      end
    end
    return qr;
  endfunction

  task automatic send_query(input query_t qr);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= qr.mode;
    qx_i       <= qr.q[0];
    qy_i       <= qr.q[1];
    qz_i       <= qr.q[2];
    ax_i       <= qr.a[0];
    ay_i       <= qr.a[1];
    az_i       <= qr.a[2];
    dir_x_i    <= qr.d[0];
    dir_y_i    <= qr.d[1];
    dir_z_i    <= qr.d[2];
    do @(posedge clk_i); while (!in_ready_o);
    pending_points.push_back(project_point(qr));
  endtask

  task automatic drain_points();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_query(make_query(ModeLine, 5, 6, 7, 100, -200, 300, 0, 0, 0));
    send_query(make_query(ModeSegment, -32768, 32767, 0, 100, -200, 300, 0, 0, 0));
    send_query(make_query(ModeRay, 32767, -32768, 1, -32768, 32767, -1, 0, 0, 0));
    send_query(make_query(ModeUnused, 1, 2, 3, 4, 5, 6, 0, 0, 0));
    send_query(make_query(ModeLine, 50, 30, -20, 0, 0, 0, 100, 0, 0));
    send_query(make_query(ModeLine, -250, 30, -20, 10, 0, 0, 100, 0, 0));
    send_query(make_query(ModeSegment, -50, 30, -20, 0, 0, 0, 100, 0, 0));
    send_query(make_query(ModeSegment, 0, 30, -20, 0, 0, 0, 100, 0, 0));
    send_query(make_query(ModeSegment, 500, 30, -20, 0, 0, 0, 100, 0, 0));
    send_query(make_query(ModeSegment, 100, 5, 5, 0, 0, 0, 100, 0, 0));
    send_query(make_query(ModeSegment, 37, 11, 12, 3, 4, 5, 70, 30, -20));
    send_query(make_query(ModeRay, -50, 30, -20, 0, 0, 0, 100, 0, 0));
    send_query(make_query(ModeRay, 0, 99, -20, 0, 0, 0, 100, 0, 0));
    send_query(make_query(ModeRay, 900, 30, -20, 0, 0, 0, 100, 0, 0));
    send_query(make_query(ModeUnused, -250, 30, -20, 10, 0, 0, 100, 0, 0));
    send_query(make_query(ModeLine, 32767, 32767, 0, 0, 32767, 0, 1, 1, 0));
    send_query(make_query(ModeLine, -32768, -32768, 0, 0, -32768, 0, 1, 1, 0));
    send_query(make_query(ModeSegment, 32767, 32767, 32767, 0, 32767, 0, 32767, 32767, 0));
    send_query(make_query(ModeLine, 32767, 32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767));
    send_query(make_query(ModeLine, -32768, -32768, -32768, -32768, -32768, -32768,
                          -32768, -32768, -32768));
    send_query(make_query(ModeLine, 32767, 32767, 32767, -32768, -32768, -32768,
                          -32768, -32768, -32768));
    send_query(make_query(ModeRay, -32768, -32768, -32768, 32767, 32767, 32767,
                          -32768, -32768, -32768));
    send_query(make_query(ModeSegment, -32768, 32767, -32768, 32767, -32768, 32767,
                          -1, 1, -32768));
  endtask

  task automatic test_random_stream(input int count);
    repeat (count) send_query(random_query());
  endtask

  task automatic test_backpressure();
    bit saved;
    saved = idle_en;
    idle_en = 1'b0;
    hold_left = HoldOffCycles;
    repeat (60) send_query(random_query());
    idle_en = saved;
  endtask

  task automatic test_pause_until_empty();
    drain_points();
    test_random_stream(170);
  endtask

  task automatic test_steady_stream();
    idle_en = 1'b0;
    test_random_stream(200);
  endtask

  initial begin
    out_ready_i = 1'b0;
    forever begin
      bit rdy;
      int stall_left;
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready_i <= rdy;
    end
  end

  always @(posedge clk_i) begin
    point_t want, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.r[0] = rx_o;
      got.r[1] = ry_o;
      got.r[2] = rz_o;
      got.status = status_o;
      if (pending_points.size() == 0) begin
        $error("result beat with no expected point: rx %0d ry %0d rz %0d status %0d",
               rx_o, ry_o, rz_o, status_o);
        mismatch_count++;
      end else begin
        want = pending_points.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got.r[i] !== want.r[i]) begin
            $error("%s mismatch: expected %0d, got %0d", axis_names[i],
                   $signed(want.r[i]), $signed(got.r[i]));
            mismatch_count++;
          end
        end
        if (got.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, got.status);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = ModeLine;
    qx_i           = '0;
    qy_i           = '0;
    qz_i           = '0;
    ax_i           = '0;
    ay_i           = '0;
    az_i           = '0;
    dir_x_i        = '0;
    dir_y_i        = '0;
    dir_z_i        = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    hold_left      = 0;
    idle_en        = 1'b1;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_stream(500);
    test_backpressure();
    test_pause_until_empty();
    test_steady_stream();

    drain_points();
    repeat (ResultLatency + 16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/plp_pkg.sv
hdl/plp_front.sv
hdl/plp_scale.sv
hdl/plp_div.sv
hdl/point_line_projection.sv
tb/sv/point_line_projection_tb.sv
